### rtl/core/arcodo_pkg.sv
// Shared types, constants and tables for the three-wheel arc odometry block.
package arcodo_pkg;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_DIV,
        OP_TRAV,
        OP_LOC0,
        OP_TERM,
        OP_CORDIC,
        OP_LSAT,
        OP_SUM,
        OP_ACC,
        OP_PUB
    } t_op;

    typedef enum logic [4:0] {
        SRC_NONE,
        SRC_L,
        SRC_R,
        SRC_S,
        SRC_K,
        SRC_DS_INV,
        SRC_DR_INV,
        SRC_NQ,
        SRC_X,
        SRC_Y,
        SRC_ANG_DT,
        SRC_ANG_MID,
        SRC_TX_SH,
        SRC_TY_SH,
        SRC_LY_CA,
        SRC_LX_SA,
        SRC_LY_SA,
        SRC_LX_CA,
        SRC_SET,
        SRC_ADD,
        SRC_SUB
    } t_src;

    typedef struct packed {
        logic valid;
        t_op  op;
        t_src src;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic dt_zero;
    } t_status;

    localparam logic [2:0] CFG_WHEEL_RADIUS = 3'd0;
    localparam logic [2:0] CFG_RIGHT_OFFSET = 3'd1;
    localparam logic [2:0] CFG_SIDE_OFFSET  = 3'd2;
    localparam logic [2:0] CFG_START_X      = 3'd3;
    localparam logic [2:0] CFG_START_Y      = 3'd4;
    localparam logic [2:0] CFG_START_THETA  = 3'd5;

    localparam logic [31:0] DEG_K       = 32'd749613;
    localparam logic [31:0] INV_RAD_Q16 = 32'd375493620;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
    // Binary angle of a half-centidegree count is count * ANG_RECIP >> ANG_SHIFT, exact below 72000.
    localparam logic [47:0] ANG_RECIP   = 48'd8006399337548;
    localparam int          ANG_SHIFT   = 27;
    localparam int          DIV_W       = 50;

    function automatic logic [31:0] f_atan(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/arcodo_ctrl.sv
// Sequencer that steps the odometry datapath through one sample.
module arcodo_ctrl import arcodo_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ISSUE  = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    typedef struct packed {
        t_op  op;
        t_src src;
    } t_uop;

    localparam logic [5:0] STEP_CHK  = 6'd9;
    localparam logic [5:0] STEP_MID  = 6'd22;
    localparam logic [5:0] STEP_LAST = 6'd33;

    function automatic t_uop f_ucode(input logic [5:0] s);
        t_uop u;
        case (s)
            6'd0:  u = '{OP_MUL, SRC_L};
            6'd1:  u = '{OP_MUL, SRC_K};
            6'd2:  u = '{OP_TRAV, SRC_L};
            6'd3:  u = '{OP_MUL, SRC_R};
            6'd4:  u = '{OP_MUL, SRC_K};
            6'd5:  u = '{OP_TRAV, SRC_R};
            6'd6:  u = '{OP_MUL, SRC_S};
            6'd7:  u = '{OP_MUL, SRC_K};
            6'd8:  u = '{OP_TRAV, SRC_S};
            6'd9:  u = '{OP_LOC0, SRC_NONE};
            6'd10: u = '{OP_MUL, SRC_DS_INV};
            6'd11: u = '{OP_DIV, SRC_NQ};
            6'd12: u = '{OP_TERM, SRC_X};
            6'd13: u = '{OP_MUL, SRC_DR_INV};
            6'd14: u = '{OP_DIV, SRC_NQ};
            6'd15: u = '{OP_TERM, SRC_Y};
            6'd16: u = '{OP_MUL, SRC_ANG_DT};
            6'd17: u = '{OP_CORDIC, SRC_NONE};
            6'd18: u = '{OP_MUL, SRC_TX_SH};
            6'd19: u = '{OP_LSAT, SRC_X};
            6'd20: u = '{OP_MUL, SRC_TY_SH};
            6'd21: u = '{OP_LSAT, SRC_Y};
            6'd22: u = '{OP_MUL, SRC_ANG_MID};
            6'd23: u = '{OP_CORDIC, SRC_NONE};
            6'd24: u = '{OP_MUL, SRC_LY_CA};
            6'd25: u = '{OP_SUM, SRC_SET};
            6'd26: u = '{OP_MUL, SRC_LX_SA};
            6'd27: u = '{OP_SUM, SRC_SUB};
            6'd28: u = '{OP_ACC, SRC_X};
            6'd29: u = '{OP_MUL, SRC_LY_SA};
            6'd30: u = '{OP_SUM, SRC_SET};
            6'd31: u = '{OP_MUL, SRC_LX_CA};
            6'd32: u = '{OP_SUM, SRC_ADD};
            6'd33: u = '{OP_ACC, SRC_Y};
            default: u = '{OP_NOP, SRC_NONE};
        endcase
        return u;
    endfunction

    t_state     r_state, n_state;
    logic [5:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    t_uop       uop;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid & ~i_out_ready;
        uop         = f_ucode(r_step);
        o_cmd       = '{1'b0, OP_NOP, SRC_NONE};
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = '{1'b1, OP_LOAD, SRC_NONE};
                    n_step  = '0;
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                o_cmd   = '{1'b1, uop.op, uop.src};
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_status.done) begin
                    if (r_step == STEP_CHK && i_status.dt_zero) begin
                        n_step  = STEP_MID;
                        n_state = ST_ISSUE;
                    end else if (r_step == STEP_LAST) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_step  = r_step + 6'd1;
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd       = '{1'b1, OP_PUB, SRC_NONE};
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/arcodo_dp.sv
// Datapath with shared multiplier, bit-serial divider, CORDIC unit and pose state.
module arcodo_dp import arcodo_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [31:0] i_left_angle,
    input  logic signed [31:0] i_right_angle,
    input  logic signed [31:0] i_side_angle,
    input  logic [15:0]        i_heading,
    output logic signed [31:0] o_x_pos,
    output logic signed [31:0] o_y_pos,
    output logic [15:0]        o_orientation
);

    localparam int CW     = $clog2(CORDIC_STEPS + 1);
    localparam int CSHIFT = 30 - FRAC_BITS;

    function automatic logic [31:0] f_mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [47:0] f_mag48(input logic signed [47:0] v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

    function automatic logic signed [31:0] f_sat(input logic [79:0] m, input logic neg);
        logic [79:0] cap;
        logic [79:0] mm;
        cap = neg ? 80'h8000_0000 : 80'h7FFF_FFFF;
        mm  = (m > cap) ? cap : m;
        return neg ? $signed(~mm[31:0] + 32'd1) : $signed(mm[31:0]);
    endfunction

    logic [15:0]        r_rad;
    logic signed [15:0] r_roff, r_soff;
    logic [31:0]        r_pl, r_pr, r_ps;
    logic [15:0]        r_por, r_orient;
    logic signed [31:0] r_x, r_y;
    logic signed [31:0] r_dl, r_dr, r_ds;
    logic signed [31:0] r_tl, r_tr, r_ts;
    logic signed [15:0] r_dt;

    logic [47:0] r_ma;
    logic [31:0] r_mb;
    logic        r_pneg, r_mbusy, r_mph;
    logic [79:0] r_pmag;

    logic [DIV_W-1:0] r_dq;
    logic [16:0]      r_drem, r_dden;
    logic [5:0]       r_dcnt;
    logic             r_dbusy;

    logic signed [33:0] r_cx, r_cy, r_cz;
    logic               r_cflip, r_cbusy;
    logic [CW-1:0]      r_ci;
    logic signed [31:0] r_sin, r_cos;

    logic signed [47:0] r_tx, r_ty;
    logic signed [31:0] r_lx, r_ly;
    logic signed [63:0] r_sum;
    logic               r_done;

    logic [47:0]        m_a;
    logic [31:0]        m_b;
    logic               m_neg;
    logic [23:0]        m_a24;
    logic [55:0]        m_prod;
    logic [DIV_W-1:0]   d_num;
    logic [16:0]        d_den;
    logic signed [18:0] ang_v;
    logic [16:0]        ang_r;
    logic [17:0]        d_sh;
    logic               d_bit;
    logic [15:0]        hd, orient;
    logic signed [16:0] dt0, dt1;
    logic signed [47:0] q_s;
    logic               q_neg;
    logic signed [31:0] z32;
    logic               z_flip;
    logic signed [33:0] z_init;
    logic signed [33:0] c_dx, c_dy, c_at;
    logic signed [63:0] p_s, acc_g, acc_s, acc_base;
    logic signed [31:0] acc_sat;
    logic [15:0]        th_v;

    always_comb begin
        m_a   = '0;
        m_b   = '0;
        m_neg = 1'b0;
        case (i_cmd.src)
            SRC_L: begin
                m_a = 48'(f_mag32(r_dl)); m_b = 32'(r_rad); m_neg = r_dl[31];
            end
            SRC_R: begin
                m_a = 48'(f_mag32(r_dr)); m_b = 32'(r_rad); m_neg = r_dr[31];
            end
            SRC_S: begin
                m_a = 48'(f_mag32(r_ds)); m_b = 32'(r_rad); m_neg = r_ds[31];
            end
            SRC_K: begin
                m_a = r_pmag[47:0]; m_b = DEG_K; m_neg = r_pneg;
            end
            SRC_DS_INV: begin
                m_a = 48'(f_mag32(r_ts)); m_b = INV_RAD_Q16; m_neg = r_ts[31];
            end
            SRC_DR_INV: begin
                m_a = 48'(f_mag32(r_tr)); m_b = INV_RAD_Q16; m_neg = r_tr[31];
            end
            SRC_ANG_DT, SRC_ANG_MID: begin
                m_a = ANG_RECIP; m_b = 32'(ang_r);
            end
            SRC_TX_SH: begin
                m_a = f_mag48(r_tx); m_b = f_mag32(r_sin); m_neg = r_tx[47] ^ r_sin[31];
            end
            SRC_TY_SH: begin
                m_a = f_mag48(r_ty); m_b = f_mag32(r_sin); m_neg = r_ty[47] ^ r_sin[31];
            end
            SRC_LY_CA: begin
                m_a = 48'(f_mag32(r_ly)); m_b = f_mag32(r_cos); m_neg = r_ly[31] ^ r_cos[31];
            end
            SRC_LX_SA: begin
                m_a = 48'(f_mag32(r_lx)); m_b = f_mag32(r_sin); m_neg = r_lx[31] ^ r_sin[31];
            end
            SRC_LY_SA: begin
                m_a = 48'(f_mag32(r_ly)); m_b = f_mag32(r_sin); m_neg = r_ly[31] ^ r_sin[31];
            end
            SRC_LX_CA: begin
                m_a = 48'(f_mag32(r_lx)); m_b = f_mag32(r_cos); m_neg = r_lx[31] ^ r_cos[31];
            end
            default: begin
                m_a = '0;
            end
        endcase
    end

    assign m_a24  = r_mph ? r_ma[47:24] : r_ma[23:0];
    assign m_prod = 56'(m_a24) * 56'(r_mb);

    always_comb begin
        ang_v = (i_cmd.src == SRC_ANG_MID) ?
                $signed({2'b00, r_orient, 1'b0}) - 19'(r_dt) : 19'(r_dt);
        if (ang_v < 0) begin
            ang_v = ang_v + 19'sd72000;
        end else if (ang_v >= 19'sd72000) begin
            ang_v = ang_v - 19'sd72000;
        end
        ang_r = ang_v[16:0];
        d_num = r_pmag[65:16];
        d_den = 17'(f_mag32(32'(r_dt)));
    end

    assign d_sh  = {r_drem, r_dq[DIV_W-1]};
    assign d_bit = (d_sh >= {1'b0, r_dden});

    always_comb begin
        hd     = (i_heading >= 16'd36000) ? i_heading - 16'd36000 : i_heading;
        orient = (hd == 16'd0) ? 16'd0 : 16'd36000 - hd;
        dt0    = $signed({1'b0, orient}) - $signed({1'b0, r_por});
        if (dt0 > 17'sd18000) begin
            dt1 = dt0 - 17'sd36000;
        end else if (dt0 <= -17'sd18000) begin
            dt1 = dt0 + 17'sd36000;
        end else begin
            dt1 = dt0;
        end
    end

    always_comb begin
        q_neg = ((i_cmd.src == SRC_X) ? r_ts[31] : r_tr[31]) ^ r_dt[15];
        q_s   = q_neg ? -$signed(r_dq[47:0]) : $signed(r_dq[47:0]);
    end

    always_comb begin
        z32    = $signed(r_pmag[ANG_SHIFT +: 32]);
        z_flip = (z32 > 32'sh4000_0000) || (z32 < -32'sh4000_0000);
        if (!z_flip) begin
            z_init = 34'(z32);
        end else if (z32 >= 0) begin
            z_init = 34'(z32) - 34'sh0_8000_0000;
        end else begin
            z_init = 34'(z32) + 34'sh0_8000_0000;
        end
        c_dx = r_cy >>> r_ci;
        c_dy = r_cx >>> r_ci;
        c_at = $signed(34'(f_atan(5'(r_ci))));
    end

    always_comb begin
        p_s      = r_pneg ? -$signed({1'b0, r_pmag[62:0]}) : $signed({1'b0, r_pmag[62:0]});
        acc_g    = r_sum >>> FRAC_BITS;
        acc_base = (i_cmd.src == SRC_X) ? 64'(r_x) : 64'(r_y);
        acc_s    = acc_base + acc_g;
        if (acc_s > 64'sh7FFF_FFFF) begin
            acc_sat = 32'sh7FFF_FFFF;
        end else if (acc_s < -64'sh8000_0000) begin
            acc_sat = -32'sh8000_0000;
        end else begin
            acc_sat = 32'(acc_s);
        end
        th_v = (i_cfg_data[15:0] >= 16'd36000) ? i_cfg_data[15:0] - 16'd36000
                                                : i_cfg_data[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad   <= 16'd512;
            r_roff  <= '0;
            r_soff  <= '0;
            r_pl    <= '0;
            r_pr    <= '0;
            r_ps    <= '0;
            r_por   <= 16'd18000;
            r_x     <= '0;
            r_y     <= '0;
            r_mbusy <= 1'b0;
            r_mph   <= 1'b0;
            r_dbusy <= 1'b0;
            r_cbusy <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WHEEL_RADIUS: r_rad  <= i_cfg_data[15:0];
                    CFG_RIGHT_OFFSET: r_roff <= $signed(i_cfg_data[15:0]);
                    CFG_SIDE_OFFSET:  r_soff <= $signed(i_cfg_data[15:0]);
                    CFG_START_X:      r_x    <= $signed(i_cfg_data);
                    CFG_START_Y:      r_y    <= $signed(i_cfg_data);
                    CFG_START_THETA:  r_por  <= th_v;
                    default: begin
                    end
                endcase
            end

            if (r_mbusy) begin
                if (!r_mph) begin
                    r_pmag <= 80'(m_prod);
                    r_mph  <= 1'b1;
                end else begin
                    r_pmag  <= r_pmag + (80'(m_prod) << 24);
                    r_mph   <= 1'b0;
                    r_mbusy <= 1'b0;
                    r_done  <= 1'b1;
                end
            end

            if (r_dbusy) begin
                r_dq   <= {r_dq[DIV_W-2:0], d_bit};
                r_drem <= d_bit ? 17'(d_sh - {1'b0, r_dden}) : d_sh[16:0];
                r_dcnt <= r_dcnt - 6'd1;
                if (r_dcnt == 6'd1) begin
                    r_dbusy <= 1'b0;
                    r_done  <= 1'b1;
                end
            end

            if (r_cbusy) begin
                if (r_ci == CW'(CORDIC_STEPS)) begin
                    r_sin   <= r_cflip ? 32'(-(r_cy >>> CSHIFT)) : 32'(r_cy >>> CSHIFT);
                    r_cos   <= r_cflip ? 32'(-(r_cx >>> CSHIFT)) : 32'(r_cx >>> CSHIFT);
                    r_cbusy <= 1'b0;
                    r_done  <= 1'b1;
                end else begin
                    if (!r_cz[33]) begin
                        r_cx <= r_cx - c_dx;
                        r_cy <= r_cy + c_dy;
                        r_cz <= r_cz - c_at;
                    end else begin
                        r_cx <= r_cx + c_dx;
                        r_cy <= r_cy - c_dy;
                        r_cz <= r_cz + c_at;
                    end
                    r_ci <= r_ci + CW'(1);
                end
            end

            if (i_cmd.valid) begin
                case (i_cmd.op)
                    OP_LOAD: begin
                        r_dl     <= $signed(i_left_angle - $signed(r_pl));
                        r_dr     <= $signed(i_right_angle - $signed(r_pr));
                        r_ds     <= $signed(i_side_angle - $signed(r_ps));
                        r_pl     <= i_left_angle;
                        r_pr     <= i_right_angle;
                        r_ps     <= i_side_angle;
                        r_orient <= orient;
                        r_por    <= orient;
                        r_dt     <= 16'(dt1);
                    end
                    OP_MUL: begin
                        r_ma    <= m_a;
                        r_mb    <= m_b;
                        r_pneg  <= m_neg;
                        r_mph   <= 1'b0;
                        r_mbusy <= 1'b1;
                    end
                    OP_DIV: begin
                        r_dq    <= d_num;
                        r_drem  <= '0;
                        r_dden  <= d_den;
                        r_dcnt  <= 6'(DIV_W);
                        r_dbusy <= 1'b1;
                    end
                    OP_TRAV: begin
                        case (i_cmd.src)
                            SRC_L:   r_tl <= f_sat(r_pmag >> 24, r_pneg);
                            SRC_R:   r_tr <= f_sat(r_pmag >> 24, r_pneg);
                            default: r_ts <= f_sat(r_pmag >> 24, r_pneg);
                        endcase
                        r_done <= 1'b1;
                    end
                    OP_LOC0: begin
                        r_lx   <= r_ts;
                        r_ly   <= r_tl;
                        r_done <= 1'b1;
                    end
                    OP_TERM: begin
                        if (i_cmd.src == SRC_X) begin
                            r_tx <= q_s + (48'(r_soff) <<< 8);
                        end else begin
                            r_ty <= q_s - (48'(r_roff) <<< 8);
                        end
                        r_done <= 1'b1;
                    end
                    OP_CORDIC: begin
                        r_cx    <= $signed(CORDIC_GAIN);
                        r_cy    <= '0;
                        r_cz    <= z_init;
                        r_cflip <= z_flip;
                        r_ci    <= '0;
                        r_cbusy <= 1'b1;
                    end
                    OP_LSAT: begin
                        if (i_cmd.src == SRC_X) begin
                            r_lx <= f_sat(r_pmag >> (FRAC_BITS - 1), r_pneg);
                        end else begin
                            r_ly <= f_sat(r_pmag >> (FRAC_BITS - 1), r_pneg);
                        end
                        r_done <= 1'b1;
                    end
                    OP_SUM: begin
                        case (i_cmd.src)
                            SRC_ADD: r_sum <= r_sum + p_s;
                            SRC_SUB: r_sum <= r_sum - p_s;
                            default: r_sum <= p_s;
                        endcase
                        r_done <= 1'b1;
                    end
                    OP_ACC: begin
                        if (i_cmd.src == SRC_X) begin
                            r_x <= acc_sat;
                        end else begin
                            r_y <= acc_sat;
                        end
                        r_done <= 1'b1;
                    end
                    OP_PUB: begin
                        o_x_pos       <= r_x;
                        o_y_pos       <= r_y;
                        o_orientation <= r_orient;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_status.done    = r_done;
    assign o_status.dt_zero = (r_dt == 16'sd0);

endmodule

### rtl/core/arc_odometry_pose_tracker.sv
// Top level of the three-wheel arc odometry pose tracker.
// A sample with a turn runs two bit-serial divisions, two CORDIC passes and multiplies;
// a straight step skips the divisions and the first CORDIC pass.
// One sample is in work at a time; the input is ready again once the result is registered,
// and a finished sample waits while an earlier result has not yet been taken.
// Reset is synchronous and active low; it restores register defaults, history and position.
module arc_odometry_pose_tracker import arcodo_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_left_angle,
    input  logic signed [31:0] i_right_angle,
    input  logic signed [31:0] i_side_angle,
    input  logic [15:0]        i_heading,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_x_pos,
    output logic signed [31:0] o_y_pos,
    output logic [15:0]        o_orientation,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    arcodo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    arcodo_dp #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_left_angle  (i_left_angle),
        .i_right_angle (i_right_angle),
        .i_side_angle  (i_side_angle),
        .i_heading     (i_heading),
        .o_x_pos       (o_x_pos),
        .o_y_pos       (o_y_pos),
        .o_orientation (o_orientation)
    );

endmodule
